[sv/rdf_pkg.sv]
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types and constants for the receive frame deframer.
// ----------------------------------------------------------------------------
package rdf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int LEN_W  = 7;
   localparam int BYTE_W = 8;
   localparam int CORR_W = 7;

   localparam logic [BYTE_W-1:0] FOOT_BYTES = 8'd2;
   localparam int                CRC_OK_BIT = 7;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic CSR_MAX_FRAME_LEN = 1'b0;
   localparam logic CSR_BUFFER_SIZE   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_BADCRC = 3'd1,
      ST_SHORT  = 3'd2,
      ST_LONG   = 3'd3,
      ST_NOSYNC = 3'd4
   } rdf_status_type;

   typedef enum logic [5:0] {
      PH_LEN    = 6'b000001,
      PH_BODY   = 6'b000010,
      PH_SHORT  = 6'b000100,
      PH_FRSSI  = 6'b001000,
      PH_FCORR  = 6'b010000,
      PH_NOSYNC = 6'b100000
   } rdf_phase_type;

   typedef struct packed {
      logic              we;
      logic              index;
      logic [LEN_W-1:0]  wdata;
   } rdf_csr_type;

   typedef struct packed {
      logic               kind;
      logic [BYTE_W-1:0]  data_byte;
      rdf_status_type     frame_status;
      logic [LEN_W-1:0]   deliver_len;
      logic               update;
      logic [BYTE_W-1:0]  rssi_hold;
      logic [CORR_W-1:0]  correlation;
   } rdf_entry_type;

endpackage

[sv/rdf_if.sv]
// ----------------------------------------------------------------------------
// rdf_if
// Valid/ready channels for deframer input items and result items.
// ----------------------------------------------------------------------------
interface rdf_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface rdf_rsp_if;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [7:0]        data_byte;
   logic [2:0]        frame_status;
   logic [6:0]        deliver_len;
   logic signed [7:0] rssi;
   logic [6:0]        correlation;

   modport source (output valid, output kind, output data_byte, output frame_status,
                   output deliver_len, output rssi, output correlation, input ready);
   modport sink   (input valid, input kind, input data_byte, input frame_status,
                   input deliver_len, input rssi, input correlation, output ready);
endinterface

[sv/rdf_front.sv]
// ----------------------------------------------------------------------------
// rdf_front
// Accepts FIFO bytes and flushes, tracks the frame phase, queues actions.
// ----------------------------------------------------------------------------
module rdf_front
   import rdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rdf_csr_type   csr,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_cmd,
   input  logic [7:0]    in_byte,
   output logic          push_valid,
   input  logic          push_ready,
   output rdf_entry_type push_entry
);

   rdf_phase_type     phase_ff, phase_in;
   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic [LEN_W-1:0]  buf_size_ff, buf_size_in;
   logic [LEN_W-1:0]  frame_len_ff, frame_len_in;
   logic [LEN_W-1:0]  seen_ff, seen_in;
   logic              long_ff, long_in;
   logic [BYTE_W-1:0] rssi_hold_ff, rssi_hold_in;

   logic              accept;
   logic [LEN_W-1:0]  seen_inc;
   logic [LEN_W-1:0]  body_len;
   logic [BYTE_W-1:0] len_minus_foot;

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;
   assign seen_inc = seen_ff + LEN_W'(1);
   assign body_len = frame_len_ff - LEN_W'(FOOT_BYTES);
   assign len_minus_foot = in_byte - FOOT_BYTES;

   always_comb begin
      max_len_in   = max_len_ff;
      buf_size_in  = buf_size_ff;
      if (csr.we) begin
         unique case (csr.index)
            CSR_MAX_FRAME_LEN: max_len_in  = csr.wdata;
            CSR_BUFFER_SIZE:   buf_size_in = csr.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      seen_in      = seen_ff;
      long_in      = long_ff;
      rssi_hold_in = rssi_hold_ff;
      push_valid   = 1'b0;
      push_entry   = '0;
      push_entry.frame_status = ST_OK;
      if (accept) begin
         if (in_cmd == CMD_FLUSH) begin
            phase_in     = PH_LEN;
            frame_len_in = '0;
            seen_in      = '0;
            long_in      = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_BODY: begin
                  seen_in = seen_inc;
                  if (seen_inc >= body_len) begin
                     phase_in = PH_FRSSI;
                  end
                  if (!long_ff || (seen_ff < buf_size_ff)) begin
                     push_valid           = 1'b1;
                     push_entry.kind      = KIND_DATA;
                     push_entry.data_byte = in_byte;
                  end
               end
               PH_SHORT: begin
                  seen_in = seen_inc;
                  if (seen_inc >= frame_len_ff) begin
                     phase_in                = PH_LEN;
                     push_valid              = 1'b1;
                     push_entry.kind         = KIND_STATUS;
                     push_entry.frame_status = ST_SHORT;
                  end
               end
               PH_FRSSI: begin
                  rssi_hold_in = in_byte;
                  phase_in     = PH_FCORR;
               end
               PH_FCORR: begin
                  phase_in        = PH_LEN;
                  push_valid      = 1'b1;
                  push_entry.kind = KIND_STATUS;
                  if (long_ff) begin
                     push_entry.frame_status = ST_LONG;
                  end else if (in_byte[CRC_OK_BIT]) begin
                     push_entry.frame_status = ST_OK;
                     push_entry.deliver_len  = body_len;
                     push_entry.update       = 1'b1;
                     push_entry.rssi_hold    = rssi_hold_ff;
                     push_entry.correlation  = in_byte[CORR_W-1:0];
                  end else begin
                     push_entry.frame_status = ST_BADCRC;
                  end
               end
               PH_NOSYNC: ;
               default: begin
                  phase_in = PH_LEN;
                  seen_in  = '0;
                  long_in  = 1'b0;
                  if (in_byte == '0) begin
                     phase_in = PH_LEN;
                  end else if (in_byte > {1'b0, max_len_ff}) begin
                     phase_in                = PH_NOSYNC;
                     push_valid              = 1'b1;
                     push_entry.kind         = KIND_STATUS;
                     push_entry.frame_status = ST_NOSYNC;
                  end else begin
                     frame_len_in = in_byte[LEN_W-1:0];
                     if (in_byte <= FOOT_BYTES) begin
                        phase_in = PH_SHORT;
                     end else begin
                        long_in  = (len_minus_foot > {1'b0, buf_size_ff});
                        phase_in = PH_BODY;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEN;
         max_len_ff   <= '1;
         buf_size_ff  <= '1;
         frame_len_ff <= '0;
         seen_ff      <= '0;
         long_ff      <= 1'b0;
         rssi_hold_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         max_len_ff   <= max_len_in;
         buf_size_ff  <= buf_size_in;
         frame_len_ff <= frame_len_in;
         seen_ff      <= seen_in;
         long_ff      <= long_in;
         rssi_hold_ff <= rssi_hold_in;
      end
   end

endmodule

[sv/rdf_queue.sv]
// ----------------------------------------------------------------------------
// rdf_queue
// Short FIFO of actions between the front and back parts.
// ----------------------------------------------------------------------------
module rdf_queue
   import rdf_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  rdf_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output rdf_entry_type pop_entry
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam logic [AW-1:0] LAST = AW'(Depth - 1);

   rdf_entry_type   slot_ff [Depth];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/rdf_back.sv]
// ----------------------------------------------------------------------------
// rdf_back
// Carries out queued actions: kept link quality and the result register.
// ----------------------------------------------------------------------------
module rdf_back
   import rdf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rdf_entry_type     pop_entry,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_kind,
   output logic [7:0]        out_data_byte,
   output logic [2:0]        out_frame_status,
   output logic [6:0]        out_deliver_len,
   output logic signed [7:0] out_rssi,
   output logic [6:0]        out_correlation
);

   logic              valid_ff, valid_in;
   logic              kind_ff;
   logic [BYTE_W-1:0] data_ff;
   rdf_status_type    status_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [BYTE_W-1:0] rssi_ff, rssi_in;
   logic [CORR_W-1:0] corr_ff, corr_in;
   logic              take;

   assign pop_ready = !valid_ff || out_ready;
   assign take      = pop_valid && pop_ready;
   assign valid_in  = take ? 1'b1 : (valid_ff && !out_ready);
   assign rssi_in   = (take && pop_entry.update) ? pop_entry.rssi_hold   : rssi_ff;
   assign corr_in   = (take && pop_entry.update) ? pop_entry.correlation : corr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rssi_ff  <= '0;
         corr_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rssi_ff  <= rssi_in;
         corr_ff  <= corr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff   <= pop_entry.kind;
         data_ff   <= pop_entry.data_byte;
         status_ff <= pop_entry.frame_status;
         len_ff    <= pop_entry.deliver_len;
      end
   end

   assign out_valid        = valid_ff;
   assign out_kind         = kind_ff;
   assign out_data_byte    = data_ff;
   assign out_frame_status = status_ff;
   assign out_deliver_len  = len_ff;
   assign out_rssi         = $signed(rssi_ff);
   assign out_correlation  = corr_ff;

endmodule

[sv/radio_rx_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// radio_rx_frame_deframer_core
// Length-prefixed radio frame deframer: payload bytes out, status per frame.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    cmd, rx_byte
//   rsp_ch   out  valid/ready    kind, data_byte, frame_status, deliver_len,
//                                rssi, correlation
//   csr_*    in   csr_we         csr_index, csr_wdata
//
// One item per cycle sustained while the action queue has room. A result goes
// from the front phase logic into the action queue, then into the output
// register, before rsp_ch.valid rises. req_ch.ready drops only when the
// action queue is full, i.e. after the result side has held back
// QueueDepth + 1 results (queue plus output register). Synchronous reset.
// ----------------------------------------------------------------------------
module radio_rx_frame_deframer_core
   import rdf_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)(
   input  logic             clock,
   input  logic             reset,
   rdf_req_if.sink          req_ch,
   rdf_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [LEN_W-1:0] csr_wdata
);

   rdf_csr_type   csr;
   rdf_entry_type push_entry, pop_entry;
   logic          push_valid, push_ready;
   logic          pop_valid, pop_ready;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   rdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_cmd     (req_ch.cmd),
      .in_byte    (req_ch.rx_byte),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rdf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rdf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .out_valid        (rsp_ch.valid),
      .out_ready        (rsp_ch.ready),
      .out_kind         (rsp_ch.kind),
      .out_data_byte    (rsp_ch.data_byte),
      .out_frame_status (rsp_ch.frame_status),
      .out_deliver_len  (rsp_ch.deliver_len),
      .out_rssi         (rsp_ch.rssi),
      .out_correlation  (rsp_ch.correlation)
   );

endmodule

[sim/radio_rx_frame_deframer_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radio_rx_frame_deframer_core_test
// Self-checking bench for the receive frame deframer: length bytes, payload,
// footer and flush items go in, payload bytes and frame status come out and
// are compared with a cycle-free model of the deframer, under random gaps,
// receiver stalls, a long receiver hold-off and several register settings.
// ----------------------------------------------------------------------------
module radio_rx_frame_deframer_core_test;
   import rdf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_ITEMS    = 200;
   localparam int NUM_PHASES     = 8;
   localparam int HOLD_CYCLES    = 150;

   localparam logic [1:0] CLS_NORMAL = 2'd0;
   localparam logic [1:0] CLS_SHORT  = 2'd1;
   localparam logic [1:0] CLS_LONG   = 2'd2;

   typedef struct {
      logic       cmd;
      logic [7:0] rx_byte;
      int         gap;
   } rx_item_type;

   typedef struct {
      logic              kind;
      logic [7:0]        data_byte;
      rdf_status_type    frame_status;
      logic [6:0]        deliver_len;
      logic signed [7:0] rssi;
      logic [6:0]        correlation;
   } rx_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [LEN_W-1:0] csr_wdata;

   rdf_req_if req_if ();
   rdf_rsp_if rsp_if ();

   radio_rx_frame_deframer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rx_item_type   fifo_items[$];
   rx_result_type due_results[$];

   // deframer model state
   logic [6:0]    cfg_max_len;
   logic [6:0]    cfg_buf_size;
   rdf_phase_type frm_phase = PH_LEN;
   logic [6:0]    frm_len   = 7'd0;
   logic [6:0]    frm_seen  = 7'd0;
   logic [1:0]    frm_class = CLS_NORMAL;
   logic [7:0]    hold_rssi = 8'd0;
   logic [7:0]    kept_rssi = 8'd0;
   logic [6:0]    kept_corr = 7'd0;

   int  items_pushed;
   int  items_taken = 0;
   int  mismatches = 0;
   int  data_results = 0;
   int  status_counts [0:4] = '{default: 0};
   int  drv_gap;
   int  rsp_wait;
   int  rcv_hold;
   bit  rsp_burst;
   bit  burst_mode;
   bit  hold_req;
   bit  hold_armed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic deframe_byte(input logic cmd, input logic [7:0] b);
      rx_result_type r;
      logic          emit;
      logic          pass;
      logic [6:0]    body;
      emit = 1'b0;
      r.kind = KIND_STATUS;
      r.data_byte = 8'd0;
      r.frame_status = ST_OK;
      r.deliver_len = 7'd0;
      if (cmd == CMD_FLUSH) begin
         frm_phase = PH_LEN;
         frm_len = 7'd0;
         frm_seen = 7'd0;
         frm_class = CLS_NORMAL;
      end else begin
         case (frm_phase)
            PH_BODY: begin
               body = frm_len - 7'd2;
               pass = (frm_class == CLS_NORMAL) || (frm_seen < cfg_buf_size);
               frm_seen = frm_seen + 7'd1;
               if (frm_seen >= body) frm_phase = PH_FRSSI;
               if (pass) begin
                  emit = 1'b1;
                  r.kind = KIND_DATA;
                  r.data_byte = b;
               end
            end
            PH_SHORT: begin
               frm_seen = frm_seen + 7'd1;
               if (frm_seen >= frm_len) begin
                  frm_phase = PH_LEN;
                  emit = 1'b1;
                  r.frame_status = ST_SHORT;
               end
            end
            PH_FRSSI: begin
               hold_rssi = b;
               frm_phase = PH_FCORR;
            end
            PH_FCORR: begin
               frm_phase = PH_LEN;
               emit = 1'b1;
               if (frm_class == CLS_LONG) begin
                  r.frame_status = ST_LONG;
               end else if (b[CRC_OK_BIT]) begin
                  kept_rssi = hold_rssi;
                  kept_corr = b[6:0];
                  r.frame_status = ST_OK;
                  r.deliver_len = frm_len - 7'd2;
               end else begin
                  r.frame_status = ST_BADCRC;
               end
            end
            PH_NOSYNC: begin
            end
            default: begin
               frm_phase = PH_LEN;
               frm_seen = 7'd0;
               frm_class = CLS_NORMAL;
               if (b == 8'd0) begin
               end else if (b > {1'b0, cfg_max_len}) begin
                  frm_phase = PH_NOSYNC;
                  emit = 1'b1;
                  r.frame_status = ST_NOSYNC;
               end else begin
                  frm_len = b[6:0];
                  if (b <= FOOT_BYTES) begin
                     frm_class = CLS_SHORT;
                     frm_phase = PH_SHORT;
                  end else begin
                     if ((b - FOOT_BYTES) > {1'b0, cfg_buf_size}) frm_class = CLS_LONG;
                     frm_phase = PH_BODY;
                  end
               end
            end
         endcase
      end
      if (emit) begin
         r.rssi = kept_rssi;
         r.correlation = kept_corr;
         due_results.push_back(r);
      end
   endtask

   // sender
   always @(posedge clock) begin
      logic        nv;
      logic        ncmd;
      logic [7:0]  nbyte;
      rx_item_type it;
      nv = req_if.valid;
      ncmd = req_if.cmd;
      nbyte = req_if.rx_byte;
      if (reset) begin
         nv = 1'b0;
         ncmd = CMD_BYTE;
         nbyte = 8'd0;
         drv_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            deframe_byte(req_if.cmd, req_if.rx_byte);
            items_taken++;
            nv = 1'b0;
         end
         if (!nv && fifo_items.size() > 0) begin
            if (drv_gap < fifo_items[0].gap) begin
               drv_gap++;
            end else begin
               it = fifo_items.pop_front();
               nv = 1'b1;
               ncmd = it.cmd;
               nbyte = it.rx_byte;
               drv_gap = 0;
            end
         end
      end
      req_if.valid <= nv;
      req_if.cmd <= ncmd;
      req_if.rx_byte <= nbyte;
   end

   task automatic check_result;
      rx_result_type e;
      if (due_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: kind=%0d data=%0d status=%0d len=%0d rssi=%0d corr=%0d",
                     rsp_if.kind, rsp_if.data_byte, rsp_if.frame_status,
                     rsp_if.deliver_len, rsp_if.rssi, rsp_if.correlation);
      end else begin
         e = due_results.pop_front();
         if (e.kind == KIND_DATA) data_results++;
         else if (e.frame_status <= ST_NOSYNC) status_counts[e.frame_status]++;
         if (rsp_if.kind !== e.kind || rsp_if.data_byte !== e.data_byte ||
             rsp_if.frame_status !== e.frame_status || rsp_if.deliver_len !== e.deliver_len ||
             rsp_if.rssi !== e.rssi || rsp_if.correlation !== e.correlation) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t: exp kind=%0d data=%0d status=%0d len=%0d rssi=%0d corr=%0d",
                        $realtime, e.kind, e.data_byte, e.frame_status, e.deliver_len,
                        e.rssi, e.correlation);
               $display("                 got kind=%0d data=%0d status=%0d len=%0d rssi=%0d corr=%0d",
                        rsp_if.kind, rsp_if.data_byte, rsp_if.frame_status,
                        rsp_if.deliver_len, rsp_if.rssi, rsp_if.correlation);
            end
         end
      end
   endtask

   // receiver
   always @(posedge clock) begin
      logic nr;
      if (reset) begin
         nr = 1'b0;
         rsp_wait = 0;
         rcv_hold = 0;
         rsp_burst = 1'b0;
         hold_armed = 1'b0;
      end else begin
         if (hold_req && !hold_armed) begin
            rcv_hold = HOLD_CYCLES;
            hold_armed = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            check_result();
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
         end
         if (rcv_hold > 0) begin
            rcv_hold--;
            nr = 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            nr = 1'b0;
         end else begin
            nr = 1'b1;
         end
      end
      rsp_if.ready <= nr;
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   task automatic push_item(input logic cmd, input logic [7:0] b);
      rx_item_type it;
      it.cmd = cmd;
      it.rx_byte = b;
      it.gap = burst_mode ? 0 : $urandom_range(0, 7);
      fifo_items.push_back(it);
      items_pushed++;
   endtask

   task automatic push_frame(input int len, input bit crc_ok);
      int k;
      push_item(CMD_BYTE, len[7:0]);
      if (len == 0) return;
      if (len > cfg_max_len) begin
         k = $urandom_range(0, 4);
         repeat (k) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         push_item(CMD_FLUSH, 8'($urandom_range(0, 255)));
      end else if (len <= 2) begin
         repeat (len) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      end else begin
         repeat (len - 2) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         push_item(CMD_BYTE, {crc_ok, 7'($urandom_range(0, 127))});
      end
   endtask

   task automatic wait_drained;
      while (items_taken != items_pushed || due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [6:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_MAX_FRAME_LEN) cfg_max_len = val;
      else cfg_buf_size = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_random_sequence;
      int sel;
      int hi;
      int len;
      int cap;
      sel = $urandom_range(0, 99);
      hi = cfg_max_len;
      cap = (hi < 24) ? hi : 24;
      burst_mode = ($urandom_range(0, 4) == 0);
      if (sel < 70 && hi >= 3) begin
         if ($urandom_range(0, 39) == 0) len = $urandom_range(3, hi);
         else len = $urandom_range(3, cap);
         push_frame(len, $urandom_range(0, 3) != 0);
      end else if (sel < 78 || (sel < 70)) begin
         push_frame($urandom_range(1, 2), 1'b1);
      end else if (sel < 83) begin
         push_frame(0, 1'b1);
      end else if (sel < 90 && hi >= 3) begin
         len = $urandom_range(3, cap);
         push_item(CMD_BYTE, len[7:0]);
         repeat ($urandom_range(0, len - 1)) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         push_item(CMD_FLUSH, 8'($urandom_range(0, 255)));
      end else if (sel < 95) begin
         push_frame($urandom_range(hi + 1, 255), 1'b1);
      end else begin
         push_item(CMD_FLUSH, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int ph_start;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_MAX_FRAME_LEN;
      csr_wdata <= '0;
      cfg_max_len = 7'd127;
      cfg_buf_size = 7'd127;
      items_pushed = 0;
      burst_mode = 1'b0;
      hold_req = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero length, ok / bad crc, short, flush mid-frame, lost sync
      push_item(CMD_BYTE, 8'd0);
      push_item(CMD_BYTE, 8'd3);
      push_item(CMD_BYTE, 8'h00);
      push_item(CMD_BYTE, 8'h80);
      push_item(CMD_BYTE, 8'hff);
      push_item(CMD_BYTE, 8'd4);
      push_item(CMD_BYTE, 8'hff);
      push_item(CMD_BYTE, 8'ha5);
      push_item(CMD_BYTE, 8'h7f);
      push_item(CMD_BYTE, 8'h00);
      push_item(CMD_BYTE, 8'd1);
      push_item(CMD_BYTE, 8'h55);
      push_item(CMD_BYTE, 8'd2);
      push_item(CMD_BYTE, 8'haa);
      push_item(CMD_BYTE, 8'h01);
      push_item(CMD_BYTE, 8'd6);
      push_item(CMD_BYTE, 8'h12);
      push_item(CMD_BYTE, 8'h34);
      push_item(CMD_FLUSH, 8'hff);
      push_item(CMD_BYTE, 8'hff);
      push_item(CMD_BYTE, 8'h00);
      push_item(CMD_FLUSH, 8'h00);
      wait_drained();

      // empty buffer: any payload is too long
      write_csr(CSR_BUFFER_SIZE, 7'd0);
      push_frame(3, 1'b1);
      wait_drained();

      // buffer grows mid-frame on a too-long frame
      write_csr(CSR_BUFFER_SIZE, 7'd5);
      push_item(CMD_BYTE, 8'd12);
      repeat (3) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      wait_drained();
      write_csr(CSR_BUFFER_SIZE, 7'd8);
      repeat (7) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      push_item(CMD_BYTE, 8'h40);
      push_item(CMD_BYTE, 8'hc1);
      wait_drained();
      write_csr(CSR_BUFFER_SIZE, 7'd127);

      // receiver holds off while the sender keeps offering
      @(negedge clock);
      hold_req = 1'b1;
      burst_mode = 1'b1;
      repeat (3) push_frame(20, 1'b1);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin write_csr(CSR_MAX_FRAME_LEN, 7'd127); write_csr(CSR_BUFFER_SIZE, 7'd127); end
            1: begin write_csr(CSR_MAX_FRAME_LEN, 7'd127); write_csr(CSR_BUFFER_SIZE, 7'd0); end
            2: begin write_csr(CSR_MAX_FRAME_LEN, 7'd0); write_csr(CSR_BUFFER_SIZE, 7'd127); end
            3: begin write_csr(CSR_MAX_FRAME_LEN, 7'd2); write_csr(CSR_BUFFER_SIZE, 7'd1); end
            4: begin write_csr(CSR_MAX_FRAME_LEN, 7'd40); write_csr(CSR_BUFFER_SIZE, 7'd10); end
            5: begin write_csr(CSR_MAX_FRAME_LEN, 7'd127); write_csr(CSR_BUFFER_SIZE, 7'd1); end
            6: begin
               write_csr(CSR_MAX_FRAME_LEN, 7'($urandom_range(0, 127)));
               write_csr(CSR_BUFFER_SIZE, 7'($urandom_range(0, 127)));
            end
            default: begin
               write_csr(CSR_MAX_FRAME_LEN, 7'd127);
               write_csr(CSR_BUFFER_SIZE, 7'd127);
            end
         endcase
         ph_start = items_pushed;
         while (items_pushed - ph_start < PHASE_ITEMS) add_random_sequence();
         wait_drained();
      end

      $display("covered %0d items over %0d register settings: %0d payload bytes,",
               items_taken, NUM_PHASES + 4, data_results);
      $display("status ok %0d, bad crc %0d, too short %0d, too long %0d, out of sync %0d",
               status_counts[0], status_counts[1], status_counts[2], status_counts[3],
               status_counts[4]);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[radio_rx_frame_deframer_core.f]
sv/rdf_pkg.sv
sv/rdf_if.sv
sv/rdf_front.sv
sv/rdf_queue.sv
sv/rdf_back.sv
sv/radio_rx_frame_deframer_core.sv
sim/radio_rx_frame_deframer_core_test.sv
